// ===== sv/cpp_pkg.sv =====
// Shared types, constants and pipeline latencies of the camera point projection.
package cpp_pkg;

  localparam int DIV_BITS   = 37;
  localparam int LAT_PROJ   = DIV_BITS + 2;
  localparam int LAT_DIST   = 9;
  localparam int LAT_SCALE  = 3;
  localparam int LAT_TOTAL  = LAT_PROJ + LAT_DIST + LAT_SCALE;
  localparam int CLIP_DLY   = LAT_DIST + LAT_SCALE;
  localparam int COORD_W    = 39;
  localparam int CFG_W      = 32;

  localparam logic [23:0] FOCAL_X_RST  = 24'd327680;
  localparam logic [23:0] FOCAL_Y_RST  = 24'd327680;
  localparam logic [23:0] CENTER_X_RST = 24'd163840;
  localparam logic [23:0] CENTER_Y_RST = 24'd131072;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_OFFSET_W = 3'd4,
    REG_OFFSET_H = 3'd5,
    REG_DIST_R2  = 3'd6,
    REG_DIST_R4  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic vld;
    logic zbad;
  } pipe_tag_t;

endpackage

// ===== sv/cpp_proj.sv =====
// One projection lane: focal multiply, pipelined long division by depth, clamp and center.
module cpp_proj (
  input  logic               clk_i,
  input  logic signed [31:0] coord_i,
  input  logic        [30:0] depth_i,
  input  logic        [23:0] focal_i,
  input  logic        [23:0] center_i,
  output cpp_pkg::coord_t    coord_o,
  output logic               clip_o
);
  import cpp_pkg::*;

  logic [31:0] pmag;
  logic [55:0] prod_q;
  logic        sgn_q;
  logic [30:0] z_q;

  assign pmag = coord_i[31] ? 32'(-coord_i) : 32'(coord_i);

  always_ff @(posedge clk_i) begin
    prod_q <= 56'(pmag) * 56'(focal_i);
    sgn_q  <= coord_i[31];
    z_q    <= depth_i;
  end

  logic [30:0]         rem_s [DIV_BITS+1];
  logic [DIV_BITS-1:0] quo_s [DIV_BITS+1];
  logic [28:0]         nb_s  [DIV_BITS+1];
  logic                ovf_s [DIV_BITS+1];
  logic                sgn_s [DIV_BITS+1];
  logic [30:0]         z_s   [DIV_BITS+1];

  assign rem_s[0] = 31'(prod_q[55:29]);
  assign quo_s[0] = '0;
  assign nb_s[0]  = prod_q[28:0];
  assign ovf_s[0] = 31'(prod_q[55:29]) >= z_q;
  assign sgn_s[0] = sgn_q;
  assign z_s[0]   = z_q;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    localparam int J = DIV_BITS - 1 - k;
    logic                nbit;
    logic [31:0]         trial;
    logic                ge;
    logic [30:0]         rem_d, rem_q;
    logic [DIV_BITS-1:0] quo_d, quo_q;
    logic [28:0]         nb_q;
    logic                ovf_q, sg_q;
    logic [30:0]         zz_q;

    if (J >= 8) begin : g_bit
      assign nbit = nb_s[k][J-8];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    always_comb begin
      trial = {rem_s[k], nbit};
      ge    = trial >= {1'b0, z_s[k]};
      rem_d = ge ? 31'(trial - {1'b0, z_s[k]}) : trial[30:0];
      quo_d = quo_s[k];
      quo_d[J] = ge;
    end

    always_ff @(posedge clk_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      nb_q  <= nb_s[k];
      ovf_q <= ovf_s[k];
      sg_q  <= sgn_s[k];
      zz_q  <= z_s[k];
    end

    assign rem_s[k+1] = rem_q;
    assign quo_s[k+1] = quo_q;
    assign nb_s[k+1]  = nb_q;
    assign ovf_s[k+1] = ovf_q;
    assign sgn_s[k+1] = sg_q;
    assign z_s[k+1]   = zz_q;
  end

  localparam logic [DIV_BITS-1:0] QLIM = {1'b1, {(DIV_BITS-1){1'b0}}};

  logic                qsat;
  logic [DIV_BITS-1:0] qm;
  coord_t              qs, coord_d, coord_q;
  logic                clip_q;

  always_comb begin
    qsat    = ovf_s[DIV_BITS] || (quo_s[DIV_BITS] > QLIM);
    qm      = qsat ? QLIM : quo_s[DIV_BITS];
    qs      = sgn_s[DIV_BITS] ? -coord_t'({2'b00, qm}) : coord_t'({2'b00, qm});
    coord_d = qs + coord_t'({center_i, 8'h00});
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
    clip_q  <= qsat;
  end

  assign coord_o = coord_q;
  assign clip_o  = clip_q;

endmodule

// ===== sv/cpp_dist.sv =====
// Radial distortion factor pipeline: squared radius, its square and the two scaled terms.
module cpp_dist (
  input  logic               clk_i,
  input  cpp_pkg::coord_t    u_i,
  input  cpp_pkg::coord_t    v_i,
  input  logic signed [11:0] offset_w_i,
  input  logic signed [11:0] offset_h_i,
  input  logic signed [31:0] dist_r2_i,
  input  logic signed [31:0] dist_r4_i,
  output logic signed [63:0] factor_o
);
  import cpp_pkg::*;

  localparam coord_t       CX_OFS   = coord_t'(640 * 65536);
  localparam coord_t       CY_OFS   = coord_t'(512 * 65536);
  localparam logic [69:0]  T2_CAP   = 70'(1) << 61;
  localparam logic [81:0]  R4_CAP   = 82'(1) << 62;
  localparam logic [62:0]  T4_CAP   = 63'(1) << 61;
  localparam logic signed [63:0] ONE_Q32 = 64'sd1 <<< 32;

  coord_t      du, dv;
  logic [38:0] dmu, dmv;
  logic [29:0] au_q, av_q;

  always_comb begin
    du  = u_i + coord_t'({{11{offset_w_i[11]}}, offset_w_i, 16'h0000}) - CX_OFS;
    dv  = v_i + coord_t'({{11{offset_h_i[11]}}, offset_h_i, 16'h0000}) - CY_OFS;
    dmu = du[COORD_W-1] ? 39'(-du) : 39'(du);
    dmv = dv[COORD_W-1] ? 39'(-dv) : 39'(dv);
  end

  logic [59:0] sqx_q, sqy_q;
  logic [60:0] r2_q;

  always_ff @(posedge clk_i) begin
    au_q  <= dmu[37:8];
    av_q  <= dmv[37:8];
    sqx_q <= 60'(au_q) * 60'(au_q);
    sqy_q <= 60'(av_q) * 60'(av_q);
    r2_q  <= 61'(sqx_q) + 61'(sqy_q);
  end

  logic [31:0] m2, m4;
  assign m2 = dist_r2_i[31] ? 32'(-dist_r2_i) : 32'(dist_r2_i);
  assign m4 = dist_r4_i[31] ? 32'(-dist_r4_i) : 32'(dist_r4_i);

  logic [62:0]  p2l_q;
  logic [61:0]  p2h_q;
  logic [61:0]  ll_q;
  logic [60:0]  lh_q;
  logic [59:0]  hh_q;
  logic [93:0]  t2p_q;
  logic [121:0] r4p_q;

  always_ff @(posedge clk_i) begin
    p2l_q <= 63'(m2) * 63'(r2_q[30:0]);
    p2h_q <= 62'(m2) * 62'(r2_q[60:31]);
    ll_q  <= 62'(r2_q[30:0]) * 62'(r2_q[30:0]);
    lh_q  <= 61'(r2_q[30:0]) * 61'(r2_q[60:31]);
    hh_q  <= 60'(r2_q[60:31]) * 60'(r2_q[60:31]);
    t2p_q <= 94'(p2l_q) + (94'(p2h_q) << 31);
    r4p_q <= 122'(ll_q) + (122'(lh_q) << 32) + (122'(hh_q) << 62);
  end

  logic [69:0]        t2sh;
  logic [61:0]        t2m;
  logic signed [63:0] t2_d, t2_q, t2b_q, t2c_q;
  logic [81:0]        r4sh;
  logic [62:0]        r4_d, r4_q;

  always_comb begin
    t2sh = 70'(t2p_q >> 24);
    t2m  = (t2sh > T2_CAP) ? 62'(T2_CAP) : t2sh[61:0];
    t2_d = dist_r2_i[31] ? -64'(t2m) : 64'(t2m);
    r4sh = 82'(r4p_q >> 40);
    r4_d = (r4sh > R4_CAP) ? 63'(R4_CAP) : r4sh[62:0];
  end

  logic [63:0] p4l_q;
  logic [62:0] p4h_q;
  logic [94:0] t4p_q;

  always_ff @(posedge clk_i) begin
    t2_q  <= t2_d;
    r4_q  <= r4_d;
    p4l_q <= 64'(m4) * 64'(r4_q[31:0]);
    p4h_q <= 63'(m4) * 63'(r4_q[62:32]);
    t2b_q <= t2_q;
    t4p_q <= 95'(p4l_q) + (95'(p4h_q) << 32);
    t2c_q <= t2b_q;
  end

  logic [62:0]        t4sh;
  logic [62:0]        t4m;
  logic signed [63:0] t4, factor_d, factor_q;

  always_comb begin
    t4sh     = t4p_q[94:32];
    t4m      = (t4sh > T4_CAP) ? T4_CAP : t4sh;
    t4       = dist_r4_i[31] ? -64'(t4m) : 64'(t4m);
    factor_d = ONE_Q32 + t2c_q + t4;
  end

  always_ff @(posedge clk_i) begin
    factor_q <= factor_d;
  end

  assign factor_o = factor_q;

endmodule

// ===== sv/cpp_scale.sv =====
// Scales one coordinate by the distortion factor, truncates toward zero and saturates to 16 bits.
module cpp_scale (
  input  logic               clk_i,
  input  cpp_pkg::coord_t    coord_i,
  input  logic signed [63:0] factor_i,
  output logic signed [15:0] pix_o,
  output logic               clip_o
);
  import cpp_pkg::*;

  logic [38:0] um;
  logic [63:0] fm;

  assign um = coord_i[COORD_W-1] ? 39'(-coord_i) : 39'(coord_i);
  assign fm = factor_i[63] ? 64'(-factor_i) : 64'(factor_i);

  logic [69:0]  pl_q;
  logic [68:0]  ph_q;
  logic [100:0] p_q;
  logic         neg1_q, neg2_q;

  always_ff @(posedge clk_i) begin
    pl_q   <= 70'(um[37:0]) * 70'(fm[31:0]);
    ph_q   <= 69'(um[37:0]) * 69'(fm[62:32]);
    neg1_q <= coord_i[COORD_W-1] ^ factor_i[63];
    p_q    <= 101'(pl_q) + (101'(ph_q) << 32);
    neg2_q <= neg1_q;
  end

  logic [52:0] pm;
  logic [16:0] lim, pmc, pv;
  logic        over;
  logic signed [15:0] pix_q;
  logic        clip_q;

  always_comb begin
    pm   = p_q[100:48];
    lim  = neg2_q ? 17'd32768 : 17'd32767;
    over = pm > 53'(lim);
    pmc  = over ? lim : pm[16:0];
    pv   = neg2_q ? 17'(-pmc) : pmc;
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pv[15:0];
    clip_q <= over;
  end

  assign pix_o  = pix_q;
  assign clip_o = clip_q;

endmodule

// ===== sv/camera_point_projection.sv =====
// Top level of the pinhole projection with radial distortion, fully pipelined.
//   channel   direction  handshake          payload
//   command   in         start, busy        cam_x_i, cam_y_i, cam_z_i
//   result    out        strobe_o           pix_u_o, pix_v_o, valid_res_o, clipped_o
//   config    in         cfg_we_i           cfg_idx_i, cfg_wdata_i
// A word is taken in every cycle that start is high; busy stays low.
// Each result passes the focal multiply, the 37 division steps of the depth divider,
// the nine stages of the distortion factor and three of scaling.
// Reset clears the valid pipeline and loads the register defaults.
// Results cannot be held off; the pipeline never stalls.
module camera_point_projection (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         cam_x_i,
  input  logic signed [31:0]         cam_y_i,
  input  logic signed [31:0]         cam_z_i,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [cpp_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic                       strobe_o,
  output logic signed [15:0]         pix_u_o,
  output logic signed [15:0]         pix_v_o,
  output logic                       valid_res_o,
  output logic                       clipped_o
);
  import cpp_pkg::*;

  logic [23:0]        focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic signed [11:0] offset_w_q, offset_h_q;
  logic signed [31:0] dist_r2_q, dist_r4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FOCAL_X_RST;
      focal_y_q  <= FOCAL_Y_RST;
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      offset_w_q <= '0;
      offset_h_q <= '0;
      dist_r2_q  <= '0;
      dist_r4_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FOCAL_X:  focal_x_q  <= cfg_wdata_i[23:0];
        REG_FOCAL_Y:  focal_y_q  <= cfg_wdata_i[23:0];
        REG_CENTER_X: center_x_q <= cfg_wdata_i[23:0];
        REG_CENTER_Y: center_y_q <= cfg_wdata_i[23:0];
        REG_OFFSET_W: offset_w_q <= cfg_wdata_i[11:0];
        REG_OFFSET_H: offset_h_q <= cfg_wdata_i[11:0];
        REG_DIST_R2:  dist_r2_q  <= cfg_wdata_i;
        REG_DIST_R4:  dist_r4_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  pipe_tag_t tag_q [LAT_TOTAL];
  pipe_tag_t tag_in;

  assign tag_in.vld  = start & ~busy;
  assign tag_in.zbad = cam_z_i[31] | (cam_z_i == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT_TOTAL; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      tag_q[0] <= tag_in;
      for (int i = 1; i < LAT_TOTAL; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  coord_t u, v;
  logic   clip_u, clip_v;

  cpp_proj u_proj_x (
    .clk_i    (clk_i),
    .coord_i  (cam_x_i),
    .depth_i  (cam_z_i[30:0]),
    .focal_i  (focal_x_q),
    .center_i (center_x_q),
    .coord_o  (u),
    .clip_o   (clip_u)
  );

  cpp_proj u_proj_y (
    .clk_i    (clk_i),
    .coord_i  (cam_y_i),
    .depth_i  (cam_z_i[30:0]),
    .focal_i  (focal_y_q),
    .center_i (center_y_q),
    .coord_o  (v),
    .clip_o   (clip_v)
  );

  logic signed [63:0] factor;

  cpp_dist u_dist (
    .clk_i      (clk_i),
    .u_i        (u),
    .v_i        (v),
    .offset_w_i (offset_w_q),
    .offset_h_i (offset_h_q),
    .dist_r2_i  (dist_r2_q),
    .dist_r4_i  (dist_r4_q),
    .factor_o   (factor)
  );

  coord_t ud_q [LAT_DIST];
  coord_t vd_q [LAT_DIST];
  logic   clp_q [CLIP_DLY];

  always_ff @(posedge clk_i) begin
    ud_q[0]  <= u;
    vd_q[0]  <= v;
    clp_q[0] <= clip_u | clip_v;
    for (int i = 1; i < LAT_DIST; i++) begin
      ud_q[i] <= ud_q[i-1];
      vd_q[i] <= vd_q[i-1];
    end
    for (int i = 1; i < CLIP_DLY; i++) begin
      clp_q[i] <= clp_q[i-1];
    end
  end

  logic signed [15:0] pu, pv;
  logic               sat_u, sat_v;

  cpp_scale u_scale_u (
    .clk_i    (clk_i),
    .coord_i  (ud_q[LAT_DIST-1]),
    .factor_i (factor),
    .pix_o    (pu),
    .clip_o   (sat_u)
  );

  cpp_scale u_scale_v (
    .clk_i    (clk_i),
    .coord_i  (vd_q[LAT_DIST-1]),
    .factor_i (factor),
    .pix_o    (pv),
    .clip_o   (sat_v)
  );

  pipe_tag_t last;
  logic      ok;

  assign last        = tag_q[LAT_TOTAL-1];
  assign ok          = last.vld & ~last.zbad;
  assign strobe_o    = last.vld;
  assign pix_u_o     = ok ? pu : '0;
  assign pix_v_o     = ok ? pv : '0;
  assign valid_res_o = ok;
  assign clipped_o   = ok & (clp_q[CLIP_DLY-1] | sat_u | sat_v);

endmodule

// ===== bench/camera_point_projection_tb.sv =====
// Self-checking testbench for the camera point projection with radial distortion.
`timescale 1ns / 1ps

module camera_point_projection_tb;
  import cpp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct {
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic               vr;
    logic               cl;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] cam_x_i = '0;
  logic signed [31:0] cam_y_i = '0;
  logic signed [31:0] cam_z_i = '0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic strobe_o;
  logic signed [15:0] pix_u_o;
  logic signed [15:0] pix_v_o;
  logic valid_res_o;
  logic clipped_o;

  point_t pending_points[$];
  pixel_t expected_pixels[$];
  bit [31:0] cam_regs[8];
  int mismatches = 0;
  int cycle_count = 0;
  bit idle_en = 1'b1;

  camera_point_projection u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cam_x_i(cam_x_i), .cam_y_i(cam_y_i), .cam_z_i(cam_z_i),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .strobe_o(strobe_o), .pix_u_o(pix_u_o), .pix_v_o(pix_v_o),
    .valid_res_o(valid_res_o), .clipped_o(clipped_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit [63:0] umag(longint a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  function automatic bit [63:0] umul_cap(bit [63:0] a, bit [63:0] b, int s, bit [63:0] cap);
    bit [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    p = p >> s;
    return (p > {64'b0, cap}) ? cap : p[63:0];
  endfunction

  function automatic longint smul_cap(longint a, longint b, int s, bit [63:0] cap);
    bit [63:0] r;
    r = umul_cap(umag(a), umag(b), s, cap);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint undistorted(logic signed [31:0] p, logic signed [31:0] z,
                                         bit [31:0] focal, bit [31:0] center, ref bit clip);
    longint num, q;
    num = longint'(p) * longint'(focal) * 256;
    q = num / longint'(z);
    if (q > (64'sd1 <<< 36)) begin
      q = 64'sd1 <<< 36;
      clip = 1'b1;
    end
    if (q < -(64'sd1 <<< 36)) begin
      q = -(64'sd1 <<< 36);
      clip = 1'b1;
    end
    return q + longint'(center) * 256;
  endfunction

  function automatic logic signed [15:0] to_pixel(longint c, longint f, ref bit clip);
    longint p;
    p = smul_cap(c, f, 48, 64'd1 << 62);
    if (p > 32767) begin
      p = 32767;
      clip = 1'b1;
    end
    if (p < -32768) begin
      p = -32768;
      clip = 1'b1;
    end
    return p[15:0];
  endfunction

  function automatic pixel_t project_point(point_t pt);
    pixel_t r;
    bit clip;
    longint u, v, du, dv, t2, t4, f;
    bit [63:0] au, av, r2, r4;
    clip = 1'b0;
    r = '{default: '0};
    if (pt.z <= 0) return r;
    u = undistorted(pt.x, pt.z, cam_regs[REG_FOCAL_X], cam_regs[REG_CENTER_X], clip);
    v = undistorted(pt.y, pt.z, cam_regs[REG_FOCAL_Y], cam_regs[REG_CENTER_Y], clip);
    du = u - (64'sd640 <<< 16) + longint'($signed(cam_regs[REG_OFFSET_W][11:0])) * 65536;
    dv = v - (64'sd512 <<< 16) + longint'($signed(cam_regs[REG_OFFSET_H][11:0])) * 65536;
    au = umag(du) >> 8;
    av = umag(dv) >> 8;
    r2 = au * au + av * av;
    t2 = smul_cap(longint'($signed(cam_regs[REG_DIST_R2])), longint'(r2), 24, 64'd1 << 61);
    r4 = umul_cap(r2, r2, 40, 64'd1 << 62);
    t4 = smul_cap(longint'($signed(cam_regs[REG_DIST_R4])), longint'(r4), 32, 64'd1 << 61);
    f = (64'sd1 <<< 32) + t2 + t4;
    r.u = to_pixel(u, f, clip);
    r.v = to_pixel(v, f, clip);
    r.vr = 1'b1;
    r.cl = clip;
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    bit go;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_pixels.push_back(project_point(pending_points[0]));
        void'(pending_points.pop_front());
      end
      go = (pending_points.size() > 0) && !(idle_en && $urandom_range(99) < 25);
      start <= go;
      if (go) begin
        cam_x_i <= pending_points[0].x;
        cam_y_i <= pending_points[0].y;
        cam_z_i <= pending_points[0].z;
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && strobe_o) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word u=%0d v=%0d", pix_u_o, pix_v_o);
      end else begin
        want = expected_pixels.pop_front();
        if (pix_u_o !== want.u || pix_v_o !== want.v || valid_res_o !== want.vr ||
            clipped_o !== want.cl) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Pixel mismatch: expected u=%0d v=%0d valid=%0b clip=%0b, got %0d %0d %0b %0b",
                     want.u, want.v, want.vr, want.cl,
                     pix_u_o, pix_v_o, valid_res_o, clipped_o);
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, bit [31:0] val);
    bit [31:0] m;
    m = (idx <= REG_CENTER_Y) ? 32'hFFFFFF : (idx <= REG_OFFSET_H) ? 32'hFFF : 32'hFFFFFFFF;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    cam_regs[idx] = val & m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_point(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    pending_points.push_back('{x: x, y: y, z: z});
  endtask

  task automatic add_random_points(int n);
    int z, s;
    repeat (n) begin
      if ($urandom_range(99) < 80) begin
        z = $urandom_range(1 << 12, 1 << 26);
        s = $urandom_range(1, 3);
        add_point(int'($urandom_range(0, 2 * s * z)) - s * z,
                  int'($urandom_range(0, 2 * s * z)) - s * z, z);
      end else begin
        add_point($urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_points.size() != 0 || start || expected_pixels.size() != 0);
    repeat (LAT_TOTAL + 4) @(posedge clk_i);
  endtask

  initial begin
    cam_regs = '{FOCAL_X_RST, FOCAL_Y_RST, CENTER_X_RST, CENTER_Y_RST, 0, 0, 0, 0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(REG_DIST_R2, -32'sd60000);
    write_reg(REG_DIST_R4, 32'sd20000000);
    @(negedge clk_i);
    add_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    add_point(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
    add_point(32'sh7FFFFFFF, 32'sh80000000, 1);
    add_point(32'sh80000000, 32'sh7FFFFFFF, 1);
    add_point(0, 0, 1);
    add_point(0, 0, 32'sh10000);
    add_point(100, 100, 0);
    add_point(100, 100, -1);
    add_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
    add_point(32'sh00010000, -32'sh00010000, 32'sh00010000);
    add_point(32'sh00200000, 32'sh00200000, 32'sh00010000);
    add_point(-32'sh00200000, -32'sh00200000, 32'sh00010000);
    add_point(32'sh00008000, 32'sh00004000, 32'sh00020000);
    add_point(32'sh01000000, 0, 32'sh00000100);
    add_point(-1, -1, 32'sh7FFFFFFF);
    add_point(32'sh00123456, -32'sh00054321, 32'sh00300000);
    add_random_points(200);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_FOCAL_X, 32'hFFFFFF);
          write_reg(REG_FOCAL_Y, 32'hFFFFFF);
          write_reg(REG_CENTER_X, 32'hFFFFFF);
          write_reg(REG_CENTER_Y, 32'hFFFFFF);
          write_reg(REG_OFFSET_W, 32'h7FF);
          write_reg(REG_OFFSET_H, 32'h7FF);
          write_reg(REG_DIST_R2, 32'h7FFFFFFF);
          write_reg(REG_DIST_R4, 32'h7FFFFFFF);
        end
        1: begin
          write_reg(REG_FOCAL_X, 0);
          write_reg(REG_FOCAL_Y, 0);
          write_reg(REG_CENTER_X, 0);
          write_reg(REG_CENTER_Y, 0);
          write_reg(REG_OFFSET_W, 32'h800);
          write_reg(REG_OFFSET_H, 32'h800);
          write_reg(REG_DIST_R2, 32'h80000000);
          write_reg(REG_DIST_R4, 32'h80000000);
        end
        default: begin
          write_reg(REG_FOCAL_X, $urandom_range(1 << 16, 1 << 20));
          write_reg(REG_FOCAL_Y, $urandom_range(1 << 16, 1 << 20));
          write_reg(REG_CENTER_X, $urandom_range(0, 1 << 19));
          write_reg(REG_CENTER_Y, $urandom_range(0, 1 << 19));
          write_reg(REG_OFFSET_W, $urandom);
          write_reg(REG_OFFSET_H, $urandom);
          write_reg(REG_DIST_R2, (ph == 7) ? $urandom : int'($urandom_range(0, 1 << 19)) - (1 << 18));
          write_reg(REG_DIST_R4, (ph == 7) ? $urandom : int'($urandom_range(0, 1 << 30)) - (1 << 29));
        end
      endcase
      idle_en = (ph != 3);
      @(negedge clk_i);
      add_random_points(205);
      drain();
    end
    mismatches += expected_pixels.size();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
